### hdl/lcw_pkg.sv
package lcw_pkg;

  // Fixed field widths of the channels and registers.
  localparam int SAMPLE_BITS     = 24;
  localparam int CNT_CFG_W       = 7;
  localparam int CAL_W           = 24;
  localparam int BAND_W          = 16;
  localparam int GRAMS_W         = 31;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;
  // Effective averaging count, wide enough for the largest supported depth of 256.
  localparam int EFF_CNT_W       = 9;
  // Divisor width of the shared divider: the widest of count, calibration and step.
  localparam int DVS_W           = 24;
  localparam int MAX_AVERAGE_DEF = 64;
  localparam int GRAM_SCALE      = 1000;

  localparam logic [GRAMS_W-1:0] GRAMS_MAX = '1;

  // Register reset values.
  localparam logic [CNT_CFG_W-1:0] AVG_COUNT_RST  = 7'd10;
  localparam logic [CNT_CFG_W-1:0] TARE_COUNT_RST = 7'd16;
  localparam logic [CAL_W-1:0]     CAL_FACTOR_RST = 24'd420;
  localparam logic [BAND_W-1:0]    ZERO_BAND_RST  = 16'd5;
  localparam logic [BAND_W-1:0]    NOISE_BAND_RST = 16'd2;
  localparam logic [BAND_W-1:0]    ROUND_STEP_RST = 16'd10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BAND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_STEP = 3'd5;

  // Operation codes.
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_TARE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_WEIGHT    = 2'd0;
  localparam logic [1:0] KIND_TARE_DONE = 2'd1;
  localparam logic [1:0] KIND_TARE_FAIL = 2'd2;

  typedef enum logic [1:0] {
    MODE_WEIGH,
    MODE_DISCARD,
    MODE_TARE
  } lcw_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_GRAM_START,
    ST_GRAM_WAIT,
    ST_STABLE,
    ST_ROUND_START,
    ST_ROUND_WAIT,
    ST_ROUND_SAT,
    ST_TARE_START,
    ST_TARE_WAIT,
    ST_EMIT
  } lcw_state_t;

  typedef struct packed {
    logic [1:0]                    operation;
    logic signed [SAMPLE_BITS-1:0] sample;
  } lcw_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [GRAMS_W-1:0] weight_grams;
    logic               error;
  } lcw_out_t;

  // Effective configuration: counts clamped, divisors never zero.
  typedef struct packed {
    logic [EFF_CNT_W-1:0] avg_n;
    logic [EFF_CNT_W-1:0] tare_n;
    logic [CAL_W-1:0]     cal;
    logic [BAND_W-1:0]    zero_band;
    logic [BAND_W-1:0]    noise_band;
    logic [BAND_W-1:0]    step;
  } lcw_cfg_t;

endpackage

### hdl/lcw_cfg.sv
module lcw_cfg #(
  parameter int MAX_AVERAGE = lcw_pkg::MAX_AVERAGE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lcw_pkg::lcw_cfg_t               cfg
);

  logic [lcw_pkg::CNT_CFG_W-1:0] avg_count_r,  avg_count_nxt;
  logic [lcw_pkg::CNT_CFG_W-1:0] tare_count_r, tare_count_nxt;
  logic [lcw_pkg::CAL_W-1:0]     cal_factor_r, cal_factor_nxt;
  logic [lcw_pkg::BAND_W-1:0]    zero_band_r,  zero_band_nxt;
  logic [lcw_pkg::BAND_W-1:0]    noise_band_r, noise_band_nxt;
  logic [lcw_pkg::BAND_W-1:0]    round_step_r, round_step_nxt;

  function automatic logic [lcw_pkg::EFF_CNT_W-1:0] clamp_cnt(
    input logic [lcw_pkg::CNT_CFG_W-1:0] c
  );
    logic [lcw_pkg::EFF_CNT_W-1:0] ce;
    ce = lcw_pkg::EFF_CNT_W'(c);
    if (c == '0) begin
      return lcw_pkg::EFF_CNT_W'(1);
    end else if (ce > lcw_pkg::EFF_CNT_W'(MAX_AVERAGE)) begin
      return lcw_pkg::EFF_CNT_W'(MAX_AVERAGE);
    end
    return ce;
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    avg_count_nxt  = avg_count_r;
    tare_count_nxt = tare_count_r;
    cal_factor_nxt = cal_factor_r;
    zero_band_nxt  = zero_band_r;
    noise_band_nxt = noise_band_r;
    round_step_nxt = round_step_r;
    if (cfg_valid) begin
      case (cfg_index)
        lcw_pkg::CFG_AVG_COUNT:  avg_count_nxt  = cfg_data[lcw_pkg::CNT_CFG_W-1:0];
        lcw_pkg::CFG_TARE_COUNT: tare_count_nxt = cfg_data[lcw_pkg::CNT_CFG_W-1:0];
        lcw_pkg::CFG_CAL_FACTOR: cal_factor_nxt = cfg_data[lcw_pkg::CAL_W-1:0];
        lcw_pkg::CFG_ZERO_BAND:  zero_band_nxt  = cfg_data[lcw_pkg::BAND_W-1:0];
        lcw_pkg::CFG_NOISE_BAND: noise_band_nxt = cfg_data[lcw_pkg::BAND_W-1:0];
        lcw_pkg::CFG_ROUND_STEP: round_step_nxt = cfg_data[lcw_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_count_r  <= lcw_pkg::AVG_COUNT_RST;
      tare_count_r <= lcw_pkg::TARE_COUNT_RST;
      cal_factor_r <= lcw_pkg::CAL_FACTOR_RST;
      zero_band_r  <= lcw_pkg::ZERO_BAND_RST;
      noise_band_r <= lcw_pkg::NOISE_BAND_RST;
      round_step_r <= lcw_pkg::ROUND_STEP_RST;
    end else begin
      avg_count_r  <= avg_count_nxt;
      tare_count_r <= tare_count_nxt;
      cal_factor_r <= cal_factor_nxt;
      zero_band_r  <= zero_band_nxt;
      noise_band_r <= noise_band_nxt;
      round_step_r <= round_step_nxt;
    end
  end

  always_comb begin
    cfg.avg_n      = clamp_cnt(avg_count_r);
    cfg.tare_n     = clamp_cnt(tare_count_r);
    cfg.cal        = (cal_factor_r == '0) ? lcw_pkg::CAL_W'(1) : cal_factor_r;
    cfg.zero_band  = zero_band_r;
    cfg.noise_band = noise_band_r;
    cfg.step       = (round_step_r == '0) ? lcw_pkg::BAND_W'(1) : round_step_r;
  end

endmodule

### hdl/lcw_div.sv
module lcw_div #(
  parameter int DIV_W = 34
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DIV_W-1:0]            dividend,
  input  logic [lcw_pkg::DVS_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [DIV_W-1:0]            quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]          quo_r, quo_nxt;
  logic [lcw_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [lcw_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [lcw_pkg::DVS_W:0]   trial;
  logic [lcw_pkg::DVS_W:0]   diff;

  // One restoring step per cycle: the dividend shifts out of the top of the
  // quotient register while quotient bits shift in at the bottom.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[lcw_pkg::DVS_W]) begin
        rem_nxt = diff[lcw_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[lcw_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hdl/load_cell_tare_and_weigh_top.sv
// Load-cell tare and weigh block.
// Input channel (in_valid/in_ready/in_data) carries an operation and a signed
// sample: a sample, a begin-tare command or a sensor timeout. Result channel
// (out_valid/out_ready/out_data) carries a kind, the rounded weight in grams
// and an error flag. The configuration channel (cfg_valid/cfg_ready/cfg_index/
// cfg_data) is always ready and writes one register per transaction.
// A sample that does not close a batch, a tare command and an unused code are
// taken in idle and leave the block ready. A timeout goes through the emit state
// to the output register. The sample that closes a weigh batch runs three passes
// through the shared restoring divider, one quotient bit per cycle. The sample
// that closes a tare runs one pass. in_ready is low from the closing sample or
// timeout until its result is loaded into the output register.
// The result waits in an output register; the next item is taken while it
// waits, and only a further result stalls until out_ready takes the first.
// Reset (rst_n low at a clock edge) restores the registers to their defaults,
// returns to weigh mode and clears offset, batch and stable weight.
module load_cell_tare_and_weigh_top #(
  parameter int MAX_AVERAGE = lcw_pkg::MAX_AVERAGE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lcw_pkg::lcw_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lcw_pkg::lcw_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SB      = lcw_pkg::SAMPLE_BITS;
  localparam int CNT_W   = $clog2(MAX_AVERAGE + 1);
  localparam int ACC_W   = SB + 1 + $clog2(MAX_AVERAGE);
  localparam int MAG_W   = ACC_W - 1;
  localparam int PROD_W  = MAG_W + 10;
  localparam int RND_W   = lcw_pkg::GRAMS_W + 1;
  localparam int DIV_A   = (MAG_W > PROD_W) ? MAG_W : PROD_W;
  localparam int DIV_W   = (DIV_A > RND_W) ? DIV_A : RND_W;
  localparam int MUL_W   = RND_W + lcw_pkg::BAND_W;
  localparam int GW      = lcw_pkg::GRAMS_W;

  lcw_pkg::lcw_cfg_t   cfg;
  lcw_pkg::lcw_state_t state_r, state_nxt;
  lcw_pkg::lcw_mode_t  mode_r, mode_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SB-1:0]           offset_r, offset_nxt;
  logic [GW-1:0]           stable_r, stable_nxt;
  logic                    acc_neg_r, acc_neg_nxt;
  logic [GW-1:0]           g_r, g_nxt;
  logic [MUL_W-1:0]        prod_r, prod_nxt;
  lcw_pkg::lcw_out_t       res_r, res_nxt;
  lcw_pkg::lcw_out_t       out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    in_fire;
  logic                    emit_load;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    avg_full;
  logic                    tare_full;
  logic [ACC_W-1:0]        sample_ext;
  logic [ACC_W-1:0]        offset_ext;
  logic [ACC_W-1:0]        acc_abs;
  logic [MAG_W-1:0]        acc_mag;
  logic [PROD_W-1:0]       scaled;
  logic [RND_W-1:0]        round_in;
  logic [GW-1:0]           g_sat;
  logic [GW-1:0]           g_diff;
  logic [SB-1:0]           q_low;
  logic [MAG_W-1:0]        avg_q;

  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [lcw_pkg::DVS_W-1:0] div_divisor;
  logic                      div_busy;
  logic                      div_done;
  logic [DIV_W-1:0]          div_quot;

  lcw_cfg #(
    .MAX_AVERAGE (MAX_AVERAGE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcw_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_ready  = (state_r == lcw_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign emit_load = (state_r == lcw_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign avg_full   = lcw_pkg::EFF_CNT_W'(cnt_inc) >= cfg.avg_n;
  assign tare_full  = lcw_pkg::EFF_CNT_W'(cnt_inc) >= cfg.tare_n;
  assign sample_ext = {{(ACC_W-SB){in_data.sample[SB-1]}}, in_data.sample};
  assign offset_ext = {{(ACC_W-SB){offset_r[SB-1]}}, offset_r};
  assign acc_abs    = acc_r[ACC_W-1] ? (ACC_W'(0) - acc_r) : acc_r;
  assign acc_mag    = acc_abs[MAG_W-1:0];
  assign q_low      = div_quot[SB-1:0];
  // An average can exceed the sample range when the count drops in the middle of a batch.
  assign avg_q      = div_quot[MAG_W-1:0];
  assign scaled     = PROD_W'(avg_q) * PROD_W'(lcw_pkg::GRAM_SCALE);
  assign round_in   = {1'b0, stable_r} + RND_W'(cfg.step >> 1);
  assign g_sat      = (div_quot > DIV_W'(lcw_pkg::GRAMS_MAX)) ? lcw_pkg::GRAMS_MAX
                                                              : div_quot[GW-1:0];
  assign g_diff     = (g_r >= stable_r) ? (g_r - stable_r) : (stable_r - g_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.operation)
            lcw_pkg::OP_TIMEOUT: state_nxt = lcw_pkg::ST_EMIT;
            lcw_pkg::OP_SAMPLE: begin
              if (mode_r == lcw_pkg::MODE_TARE && tare_full) begin
                state_nxt = lcw_pkg::ST_TARE_START;
              end else if (mode_r == lcw_pkg::MODE_WEIGH && avg_full) begin
                state_nxt = lcw_pkg::ST_AVG_START;
              end
            end
            default: ;
          endcase
        end
      end
      lcw_pkg::ST_AVG_START:   state_nxt = lcw_pkg::ST_AVG_WAIT;
      lcw_pkg::ST_AVG_WAIT:    if (div_done) state_nxt = lcw_pkg::ST_GRAM_START;
      lcw_pkg::ST_GRAM_START:  state_nxt = lcw_pkg::ST_GRAM_WAIT;
      lcw_pkg::ST_GRAM_WAIT:   if (div_done) state_nxt = lcw_pkg::ST_STABLE;
      lcw_pkg::ST_STABLE:      state_nxt = lcw_pkg::ST_ROUND_START;
      lcw_pkg::ST_ROUND_START: state_nxt = lcw_pkg::ST_ROUND_WAIT;
      lcw_pkg::ST_ROUND_WAIT:  if (div_done) state_nxt = lcw_pkg::ST_ROUND_SAT;
      lcw_pkg::ST_ROUND_SAT:   state_nxt = lcw_pkg::ST_EMIT;
      lcw_pkg::ST_TARE_START:  state_nxt = lcw_pkg::ST_TARE_WAIT;
      lcw_pkg::ST_TARE_WAIT:   if (div_done) state_nxt = lcw_pkg::ST_EMIT;
      lcw_pkg::ST_EMIT:        if (emit_load) state_nxt = lcw_pkg::ST_IDLE;
      default:                 state_nxt = lcw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    offset_nxt    = offset_r;
    stable_nxt    = stable_r;
    acc_neg_nxt   = acc_neg_r;
    g_nxt         = g_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    div_start     = 1'b0;
    div_dividend  = DIV_W'(acc_mag);
    div_divisor   = lcw_pkg::DVS_W'(cfg.avg_n);
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      lcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.operation)
            lcw_pkg::OP_TARE: begin
              offset_nxt = '0;
              acc_nxt    = '0;
              cnt_nxt    = '0;
              mode_nxt   = lcw_pkg::MODE_DISCARD;
            end
            lcw_pkg::OP_TIMEOUT: begin
              acc_nxt = '0;
              cnt_nxt = '0;
              if (mode_r != lcw_pkg::MODE_WEIGH) begin
                offset_nxt = '0;
                mode_nxt   = lcw_pkg::MODE_WEIGH;
                res_nxt    = '{kind: lcw_pkg::KIND_TARE_FAIL, weight_grams: '0, error: 1'b1};
              end else begin
                res_nxt    = '{kind: lcw_pkg::KIND_WEIGHT, weight_grams: '0, error: 1'b1};
              end
            end
            lcw_pkg::OP_SAMPLE: begin
              case (mode_r)
                lcw_pkg::MODE_DISCARD: mode_nxt = lcw_pkg::MODE_TARE;
                lcw_pkg::MODE_TARE: begin
                  acc_nxt = acc_r + sample_ext;
                  cnt_nxt = tare_full ? '0 : cnt_inc;
                end
                default: begin
                  acc_nxt = acc_r + sample_ext - offset_ext;
                  cnt_nxt = avg_full ? '0 : cnt_inc;
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      lcw_pkg::ST_AVG_START: begin
        div_start = 1'b1;
        acc_nxt   = '0;
      end
      lcw_pkg::ST_GRAM_START: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(scaled);
        div_divisor  = lcw_pkg::DVS_W'(cfg.cal);
      end
      lcw_pkg::ST_GRAM_WAIT: begin
        if (div_done) begin
          g_nxt = (g_sat < GW'(cfg.zero_band)) ? '0 : g_sat;
        end
      end
      lcw_pkg::ST_STABLE: begin
        if (g_diff > GW'(cfg.noise_band)) begin
          stable_nxt = g_r;
        end
      end
      lcw_pkg::ST_ROUND_START: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(round_in);
        div_divisor  = lcw_pkg::DVS_W'(cfg.step);
      end
      lcw_pkg::ST_ROUND_WAIT: begin
        if (div_done) begin
          prod_nxt = MUL_W'(div_quot[RND_W-1:0]) * MUL_W'(cfg.step);
        end
      end
      lcw_pkg::ST_ROUND_SAT: begin
        res_nxt.kind         = lcw_pkg::KIND_WEIGHT;
        res_nxt.error        = 1'b0;
        res_nxt.weight_grams = (prod_r > MUL_W'(lcw_pkg::GRAMS_MAX)) ? lcw_pkg::GRAMS_MAX
                                                                     : prod_r[GW-1:0];
      end
      lcw_pkg::ST_TARE_START: begin
        div_start   = 1'b1;
        div_divisor = lcw_pkg::DVS_W'(cfg.tare_n);
        acc_neg_nxt = acc_r[ACC_W-1];
        acc_nxt     = '0;
      end
      lcw_pkg::ST_TARE_WAIT: begin
        if (div_done) begin
          // The tare average of raw samples fits the sample width unless the count drops mid-batch.
          offset_nxt = acc_neg_r ? (SB'(0) - q_low) : q_low;
          mode_nxt   = lcw_pkg::MODE_WEIGH;
          res_nxt    = '{kind: lcw_pkg::KIND_TARE_DONE, weight_grams: '0, error: 1'b0};
        end
      end
      lcw_pkg::ST_EMIT: begin
        if (emit_load) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcw_pkg::ST_IDLE;
      mode_r      <= lcw_pkg::MODE_WEIGH;
      acc_r       <= '0;
      cnt_r       <= '0;
      offset_r    <= '0;
      stable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      offset_r    <= offset_nxt;
      stable_r    <= stable_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_neg_r <= acc_neg_nxt;
    g_r       <= g_nxt;
    prod_r    <= prod_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == lcw_pkg::ST_AVG_WAIT || state_r == lcw_pkg::ST_GRAM_WAIT ||
                  state_r == lcw_pkg::ST_ROUND_WAIT || state_r == lcw_pkg::ST_TARE_WAIT))
    else $error("divider finished outside a wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(MAX_AVERAGE))
    else $error("sample count reached the averaging depth");

  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == lcw_pkg::MODE_DISCARD) |-> (acc_r == '0 && cnt_r == '0))
    else $error("batch state not cleared while discarding");

  a_status_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != lcw_pkg::KIND_WEIGHT) |-> out_data.weight_grams == '0)
    else $error("tare result carries a weight");
`endif

endmodule

### bench/load_cell_tare_and_weigh_top_tb.sv
`timescale 1ns / 1ps

module load_cell_tare_and_weigh_top_tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 160;
  localparam int MAX_SHOWN     = 10;
  localparam longint GRAMS_CEIL = longint'(lcw_pkg::GRAMS_MAX);
  localparam int SB  = lcw_pkg::SAMPLE_BITS;
  localparam int IXW = lcw_pkg::CFG_IDX_W;
  localparam int DW  = lcw_pkg::CFG_DATA_W;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [IXW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IXW-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {
    PACE_STEADY,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  lcw_pkg::lcw_in_t      in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  lcw_pkg::lcw_out_t     out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IXW-1:0]        cfg_index;
  logic [DW-1:0]         cfg_data;

  load_cell_tare_and_weigh_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the registers and the scale's state.
  logic [lcw_pkg::CNT_CFG_W-1:0] avg_count_r;
  logic [lcw_pkg::CNT_CFG_W-1:0] tare_count_r;
  logic [lcw_pkg::CAL_W-1:0]     cal_factor_r;
  logic [lcw_pkg::BAND_W-1:0]    zero_band_r;
  logic [lcw_pkg::BAND_W-1:0]    noise_band_r;
  logic [lcw_pkg::BAND_W-1:0]    round_step_r;

  lcw_pkg::lcw_mode_t scale_mode    = lcw_pkg::MODE_WEIGH;
  longint             scale_acc     = 0;
  longint             tare_offset_g = 0;
  longint             stable_g      = 0;
  int unsigned        batch_fill    = 0;
  bit                 err_latch     = 1'b0;

  lcw_pkg::lcw_out_t expected_readings[$];
  lcw_pkg::lcw_in_t  sample_stream[$];

  // Stimulus shaping.
  longint bench_base;
  longint last_load;
  int     noise_amp;
  int     in_idle_pct;
  int     out_stall_pct;

  logic in_fire_q  = 1'b0;
  logic cfg_fire_q = 1'b0;

  int cycles         = 0;
  int n_queued;
  int n_gen;
  int n_taken        = 0;
  int n_checked      = 0;
  int n_bad          = 0;
  int n_settings;
  int n_readings     = 0;
  int n_tares_done   = 0;
  int n_tares_failed = 0;
  int n_timeouts     = 0;

  function automatic longint depth_of(logic [lcw_pkg::CNT_CFG_W-1:0] c);
    if (c == '0) return 1;
    if (c > lcw_pkg::MAX_AVERAGE_DEF) return lcw_pkg::MAX_AVERAGE_DEF;
    return longint'(c);
  endfunction

  function automatic void post_result(logic [1:0] kind, longint grams, logic err);
    lcw_pkg::lcw_out_t r;
    r.kind         = kind;
    r.weight_grams = grams[lcw_pkg::GRAMS_W-1:0];
    r.error        = err;
    expected_readings.push_back(r);
  endfunction

  // Closes a weigh batch: average, scale to grams, zero band, noise band, rounding.
  function automatic longint settle_grams();
    longint avg, cal, step, g, diff, r;
    avg  = scale_acc / depth_of(avg_count_r);
    cal  = (cal_factor_r == '0) ? 64'sd1 : longint'(cal_factor_r);
    step = (round_step_r == '0) ? 64'sd1 : longint'(round_step_r);
    g = (avg * 1000) / cal;
    if (g < 0) g = -g;
    if (g > GRAMS_CEIL) g = GRAMS_CEIL;
    if (g < longint'(zero_band_r)) g = 0;
    diff = g - stable_g;
    if (diff < 0) diff = -diff;
    if (diff > longint'(noise_band_r)) stable_g = g;
    r = ((stable_g + step / 2) / step) * step;
    if (r > GRAMS_CEIL) r = GRAMS_CEIL;
    return r;
  endfunction

  function automatic void apply_to_scale(lcw_pkg::lcw_in_t item);
    longint s;
    s = longint'($signed(item.sample));
    case (item.operation)
      lcw_pkg::OP_TARE: begin
        tare_offset_g = 0;
        err_latch     = 1'b0;
        scale_acc     = 0;
        batch_fill    = 0;
        scale_mode    = lcw_pkg::MODE_DISCARD;
      end
      lcw_pkg::OP_TIMEOUT: begin
        err_latch  = 1'b1;
        scale_acc  = 0;
        batch_fill = 0;
        if (scale_mode != lcw_pkg::MODE_WEIGH) begin
          tare_offset_g = 0;
          scale_mode    = lcw_pkg::MODE_WEIGH;
          post_result(lcw_pkg::KIND_TARE_FAIL, 0, 1'b1);
        end else begin
          post_result(lcw_pkg::KIND_WEIGHT, 0, 1'b1);
        end
      end
      lcw_pkg::OP_SAMPLE: begin
        if (scale_mode == lcw_pkg::MODE_DISCARD) begin
          scale_mode = lcw_pkg::MODE_TARE;
        end else if (scale_mode == lcw_pkg::MODE_TARE) begin
          scale_acc += s;
          batch_fill++;
          if (batch_fill >= depth_of(tare_count_r)) begin
            tare_offset_g = scale_acc / depth_of(tare_count_r);
            scale_acc     = 0;
            batch_fill    = 0;
            scale_mode    = lcw_pkg::MODE_WEIGH;
            post_result(lcw_pkg::KIND_TARE_DONE, 0, 1'b0);
          end
        end else begin
          // The first sample of a reading clears a latched timeout.
          if (batch_fill == 0) err_latch = 1'b0;
          scale_acc += s - tare_offset_g;
          batch_fill++;
          if (batch_fill >= depth_of(avg_count_r)) begin
            post_result(lcw_pkg::KIND_WEIGHT, settle_grams(), 1'b0);
            scale_acc  = 0;
            batch_fill = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void log_mismatch(string what, lcw_pkg::lcw_out_t want,
                                       lcw_pkg::lcw_out_t got);
    n_bad++;
    if (n_bad <= MAX_SHOWN)
      $display("%0t %s: expected kind %0d grams %0d err %0d, got kind %0d grams %0d err %0d",
               $realtime, what, want.kind, want.weight_grams, want.error,
               got.kind, got.weight_grams, got.error);
  endfunction

  // Handshakes, checking and prediction all happen on the rising edge.
  always @(posedge clk) begin : watch
    lcw_pkg::lcw_out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               CYCLE_LIMIT, expected_readings.size());
      $display("** load_cell_tare_and_weigh_top: FAILED **");
      $finish;
    end else begin
      in_fire_q  <= rst_n && in_valid && in_ready;
      cfg_fire_q <= rst_n && cfg_valid && cfg_ready;
      if (rst_n && out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          log_mismatch("result with none due", '0, out_data);
        end else begin
          want = expected_readings.pop_front();
          n_checked++;
          if (want.kind == lcw_pkg::KIND_TARE_DONE) n_tares_done++;
          else if (want.kind == lcw_pkg::KIND_TARE_FAIL) n_tares_failed++;
          else if (want.error) n_timeouts++;
          else n_readings++;
          if (out_data.kind !== want.kind || out_data.weight_grams !== want.weight_grams ||
              out_data.error !== want.error)
            log_mismatch("mismatch", want, out_data);
        end
      end
      // A result never leaves in the cycle its item is taken, so check before predicting.
      if (rst_n && in_valid && in_ready) begin
        n_taken++;
        apply_to_scale(in_data);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire_q)) begin
      if (sample_stream.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= sample_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic logic [SB-1:0] any_sample();
    return SB'($urandom);
  endfunction

  // A sample near the given level, with a little converter noise.
  function automatic logic [SB-1:0] raw_at(longint level);
    longint v;
    v = level + longint'($urandom_range(0, 2 * noise_amp)) - noise_amp;
    return v[SB-1:0];
  endfunction

  function automatic longint pick_level();
    if ($urandom_range(3) == 0) return longint'($signed(any_sample()));
    return longint'($urandom_range(0, 400000)) - 200000;
  endfunction

  function automatic longint pick_load();
    longint cal, l;
    cal = (cal_factor_r == '0) ? 64'sd1 : longint'(cal_factor_r);
    case ($urandom_range(3))
      0:       l = 0;
      1:       l = longint'($urandom_range(0, 2 * zero_band_r + 40)) * cal / 1000;
      2:       l = longint'($urandom_range(0, 50000)) * cal / 1000;
      default: l = longint'($urandom_range(0, 8388607));
    endcase
    return $urandom_range(1) ? -l : l;
  endfunction

  task automatic queue_op(logic [1:0] op, logic [SB-1:0] s);
    lcw_pkg::lcw_in_t item;
    item.operation = op;
    item.sample    = s;
    sample_stream.push_back(item);
    n_queued++;
    if (op != OP_UNUSED) n_gen++;
  endtask

  task automatic tare_run(bit restart);
    int k;
    bench_base = pick_level();
    noise_amp  = $urandom_range(0, 6);
    queue_op(lcw_pkg::OP_TARE, any_sample());
    if (restart) begin
      // A second tare command in the middle of the first starts over.
      k = $urandom_range(0, 3);
      repeat (k) queue_op(lcw_pkg::OP_SAMPLE, any_sample());
      queue_op(lcw_pkg::OP_TARE, any_sample());
    end
    queue_op(lcw_pkg::OP_SAMPLE, any_sample());
    repeat (int'(depth_of(tare_count_r))) queue_op(lcw_pkg::OP_SAMPLE, raw_at(bench_base));
  endtask

  task automatic weigh_runs(int batches);
    noise_amp = $urandom_range(0, 6);
    for (int b = 0; b < batches; b++) begin
      // Reusing the load keeps the reading inside the noise band now and then.
      if (b == 0 || $urandom_range(9) >= 4) last_load = pick_load();
      repeat (int'(depth_of(avg_count_r)))
        queue_op(lcw_pkg::OP_SAMPLE, raw_at(bench_base + last_load));
    end
  endtask

  task automatic fill_random(int budget);
    int start, pick, k;
    start = n_gen;
    while (n_gen - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        tare_run($urandom_range(9) == 0);
        weigh_runs($urandom_range(1, 3));
      end else if (pick < 75) begin
        weigh_runs($urandom_range(1, 4));
      end else if (pick < 83) begin
        // Tare cut short by a timeout, either while discarding or while averaging.
        queue_op(lcw_pkg::OP_TARE, any_sample());
        k = $urandom_range(0, int'(depth_of(tare_count_r)));
        repeat (k) queue_op(lcw_pkg::OP_SAMPLE, any_sample());
        queue_op(lcw_pkg::OP_TIMEOUT, any_sample());
      end else if (pick < 90) begin
        k = $urandom_range(0, int'(depth_of(avg_count_r)) - 1);
        repeat (k) queue_op(lcw_pkg::OP_SAMPLE, raw_at(bench_base + last_load));
        queue_op(lcw_pkg::OP_TIMEOUT, any_sample());
      end else if (pick < 93) begin
        queue_op(OP_UNUSED, any_sample());
      end else begin
        repeat ($urandom_range(1, 5)) queue_op(lcw_pkg::OP_SAMPLE, any_sample());
      end
    end
  endtask

  task automatic set_pace(pace_t pace);
    case (pace)
      PACE_SENDER_GAPS:     begin in_idle_pct = 76; out_stall_pct = 0;  end
      PACE_RECEIVER_STALLS: begin in_idle_pct = 0;  out_stall_pct = 76; end
      PACE_BOTH:            begin in_idle_pct = 18; out_stall_pct = 18; end
      default:              begin in_idle_pct = 0;  out_stall_pct = 0;  end
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_taken != n_queued || expected_readings.size() != 0);
    // The last item may have been one that produces nothing while a batch is still closing.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [IXW-1:0] idx, logic [DW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire_q);
    cfg_valid <= 1'b0;
    case (idx)
      lcw_pkg::CFG_AVG_COUNT:  avg_count_r  = val[lcw_pkg::CNT_CFG_W-1:0];
      lcw_pkg::CFG_TARE_COUNT: tare_count_r = val[lcw_pkg::CNT_CFG_W-1:0];
      lcw_pkg::CFG_CAL_FACTOR: cal_factor_r = val[lcw_pkg::CAL_W-1:0];
      lcw_pkg::CFG_ZERO_BAND:  zero_band_r  = val[lcw_pkg::BAND_W-1:0];
      lcw_pkg::CFG_NOISE_BAND: noise_band_r = val[lcw_pkg::BAND_W-1:0];
      lcw_pkg::CFG_ROUND_STEP: round_step_r = val[lcw_pkg::BAND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_scale(int avg_n, int tare_n, int cal, int zb, int nb, int step);
    write_reg(lcw_pkg::CFG_AVG_COUNT,  DW'(avg_n));
    write_reg(lcw_pkg::CFG_TARE_COUNT, DW'(tare_n));
    write_reg(lcw_pkg::CFG_CAL_FACTOR, DW'(cal));
    write_reg(lcw_pkg::CFG_ZERO_BAND,  DW'(zb));
    write_reg(lcw_pkg::CFG_NOISE_BAND, DW'(nb));
    write_reg(lcw_pkg::CFG_ROUND_STEP, DW'(step));
    n_settings++;
  endtask

  task automatic run_random(int budget, pace_t pace);
    @(posedge clk);
    set_pace(pace);
    fill_random(budget);
    wait_drained();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    avg_count_r  = lcw_pkg::AVG_COUNT_RST;
    tare_count_r = lcw_pkg::TARE_COUNT_RST;
    cal_factor_r = lcw_pkg::CAL_FACTOR_RST;
    zero_band_r  = lcw_pkg::ZERO_BAND_RST;
    noise_band_r = lcw_pkg::NOISE_BAND_RST;
    round_step_r = lcw_pkg::ROUND_STEP_RST;
    bench_base = 0;
    last_load  = 0;
    noise_amp  = 0;
    n_queued = 0; n_gen = 0; n_settings = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass with two-sample batches and tares.
    write_reg(lcw_pkg::CFG_AVG_COUNT, DW'(2));
    write_reg(lcw_pkg::CFG_TARE_COUNT, DW'(2));
    n_settings++;
    @(posedge clk);
    set_pace(PACE_STEADY);
    queue_op(OP_UNUSED, any_sample());
    queue_op(lcw_pkg::OP_TIMEOUT, any_sample());
    repeat (2) queue_op(lcw_pkg::OP_SAMPLE, 24'h7FFFFF);
    repeat (2) queue_op(lcw_pkg::OP_SAMPLE, 24'h800000);
    queue_op(lcw_pkg::OP_SAMPLE, 24'h000000);
    queue_op(lcw_pkg::OP_TIMEOUT, any_sample());
    queue_op(lcw_pkg::OP_SAMPLE, 24'h000001);
    queue_op(lcw_pkg::OP_SAMPLE, 24'hFFFFFF);
    queue_op(lcw_pkg::OP_TARE, any_sample());
    queue_op(lcw_pkg::OP_TARE, any_sample());
    queue_op(lcw_pkg::OP_SAMPLE, any_sample());
    queue_op(lcw_pkg::OP_SAMPLE, 24'd1000);
    queue_op(lcw_pkg::OP_SAMPLE, 24'd1003);
    repeat (2) queue_op(lcw_pkg::OP_SAMPLE, 24'd1043);
    repeat (2) queue_op(lcw_pkg::OP_SAMPLE, 24'd1044);
    queue_op(lcw_pkg::OP_TARE, any_sample());
    queue_op(lcw_pkg::OP_TIMEOUT, any_sample());
    queue_op(lcw_pkg::OP_TARE, any_sample());
    queue_op(lcw_pkg::OP_SAMPLE, any_sample());
    queue_op(lcw_pkg::OP_SAMPLE, 24'd5);
    queue_op(lcw_pkg::OP_TIMEOUT, any_sample());
    wait_drained();

    program_scale(10, 16, 420, 5, 2, 10);
    run_random(300, PACE_SENDER_GAPS);

    // Full-scale readings with a step that pushes the rounding past the top.
    program_scale(1, 1, 1, 0, 0, 4);
    run_random(150, PACE_RECEIVER_STALLS);

    program_scale(64, 64, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(250, PACE_BOTH);

    // Zero counts and divisors behave as one.
    program_scale(0, 0, 0, 0, 0, 0);
    run_random(150, PACE_STEADY);

    // Counts above the averaging depth are clamped; the spare indexes are ignored.
    program_scale(127, 65, 1000, 20, 10, 5);
    write_reg(CFG_SPARE_LO, any_sample());
    write_reg(CFG_SPARE_HI, any_sample());
    run_random(200, PACE_RECEIVER_STALLS);

    program_scale($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 5000),
                  $urandom_range(0, 100), $urandom_range(0, 50), $urandom_range(1, 200));
    run_random(200, PACE_SENDER_GAPS);

    program_scale($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 5000),
                  $urandom_range(0, 100), $urandom_range(0, 50), $urandom_range(1, 200));
    run_random(200, PACE_BOTH);

    program_scale($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 24'hFFFFFF),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(1, 65535));
    run_random(200, PACE_STEADY);

    $display("Sent %0d transactions under %0d register settings; %0d checked, %0d wrong",
             n_taken, n_settings, n_checked, n_bad);
    $display("Seen: %0d readings, %0d timeouts in weigh, %0d tares done, %0d tares failed",
             n_readings, n_timeouts, n_tares_done, n_tares_failed);
    if (n_bad == 0) begin
      $display("** load_cell_tare_and_weigh_top: PASSED **");
    end else begin
      $display("** load_cell_tare_and_weigh_top: FAILED **");
    end
    $finish;
  end

endmodule
